// File: rtl/core/ble_pkg.sv
// shared types, widths and codes for the byte list engine
package ble_pkg;

    localparam int CAPACITY = 64;
    localparam int FILL_W   = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int POS_W    = 7;
    localparam int CMP_W    = (FILL_W > POS_W) ? FILL_W : POS_W;
    localparam int CNT_W    = FILL_W;

    typedef enum logic [3:0] {
        REQ_PUSH    = 4'd0,
        REQ_POP     = 4'd1,
        REQ_INSERT  = 4'd2,
        REQ_REMOVE  = 4'd3,
        REQ_COUNT   = 4'd4,
        REQ_INDEX   = 4'd5,
        REQ_MAX     = 4'd6,
        REQ_MIN     = 4'd7,
        REQ_REVERSE = 4'd8,
        REQ_CLEAR   = 4'd9,
        REQ_LENGTH  = 4'd10
    } req_code_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_BADPOS   = 3'd4
    } status_code_t;

    typedef struct packed {
        logic [3:0]       req_type;
        logic [7:0]       value;
        logic [POS_W-1:0] position;
    } ble_req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] result_value;
        logic [6:0] match_count;
        logic [5:0] found_index;
        logic [6:0] list_length;
    } ble_rsp_t;

    typedef enum logic [1:0] {
        RED_MAX,
        RED_MIN,
        RED_LAST
    } red_mode_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_PUSH,
        ACT_POP,
        ACT_INSERT,
        ACT_REMOVE,
        ACT_CLEAR
    } act_t;

    typedef struct packed {
        logic             hit;
        logic [7:0]       val;
        logic [CNT_W-1:0] cnt;
        logic [IDX_W-1:0] idx;
    } ble_acc_t;

    typedef struct packed {
        logic             load;
        logic             sweep;
        logic             swap_en;
        logic             phase;
        red_mode_t        red_mode;
        act_t             action;
        logic [CMP_W-1:0] fill;
        logic [CMP_W-1:0] pos;
        logic [7:0]       value;
        logic [IDX_W-1:0] rm_idx;
        ble_acc_t         ident;
    } ble_ctl_t;

endpackage

// File: rtl/core/ble_cell.sv
// one list cell: stored byte, reverse tag and reduction stage
module ble_cell import ble_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] cell_index,
    input  ble_ctl_t         ctl,
    input  logic [7:0]       left_data,
    input  logic [IDX_W-1:0] left_tag,
    input  logic [7:0]       right_data,
    input  logic [IDX_W-1:0] right_tag,
    input  ble_acc_t         acc_in,
    output logic [7:0]       data,
    output logic [IDX_W-1:0] tag,
    output ble_acc_t         acc
);

    logic [7:0]       data_reg, data_next;
    logic [IDX_W-1:0] tag_reg, tag_next;
    ble_acc_t         acc_reg, acc_next, acc_calc;
    logic [CMP_W-1:0] k, kp1;
    logic             in_list, match, is_left, swap_left, swap_right;

    always_comb
    begin
        k          = CMP_W'(cell_index);
        kp1        = k + CMP_W'(1);
        in_list    = k < ctl.fill;
        match      = in_list && (data_reg == ctl.value);
        is_left    = cell_index[0] == ctl.phase;
        swap_left  = is_left && (kp1 < ctl.fill) && (tag_reg < right_tag);
        swap_right = !is_left && (cell_index != '0) && in_list && (left_tag < tag_reg);

        acc_calc.hit = acc_in.hit | match;
        acc_calc.idx = match ? cell_index : acc_in.idx;
        acc_calc.cnt = acc_in.cnt + CNT_W'(match);
        case (ctl.red_mode)
            RED_MAX:  acc_calc.val = (in_list && data_reg > acc_in.val) ? data_reg : acc_in.val;
            RED_MIN:  acc_calc.val = (in_list && data_reg < acc_in.val) ? data_reg : acc_in.val;
            RED_LAST: acc_calc.val = (kp1 == ctl.fill) ? data_reg : acc_in.val;
            default:  acc_calc.val = acc_in.val;
        endcase

        acc_next = acc_reg;
        if (ctl.load)
            acc_next = ctl.ident;
        else if (ctl.sweep)
            acc_next = acc_calc;

        tag_next  = tag_reg;
        data_next = data_reg;
        if (ctl.load)
        begin
            tag_next = cell_index;
        end
        else if (ctl.sweep && ctl.swap_en)
        begin
            if (swap_left)
            begin
                tag_next  = right_tag;
                data_next = right_data;
            end
            else if (swap_right)
            begin
                tag_next  = left_tag;
                data_next = left_data;
            end
        end

        case (ctl.action)
            ACT_NONE:   ;
            ACT_PUSH:
                if (k == ctl.fill)
                    data_next = ctl.value;
            ACT_POP:
                if (kp1 == ctl.fill)
                    data_next = '0;
            ACT_INSERT:
                if (k == ctl.pos)
                    data_next = ctl.value;
                else if (k > ctl.pos && k <= ctl.fill)
                    data_next = left_data;
            ACT_REMOVE:
                if (cell_index >= ctl.rm_idx && kp1 < ctl.fill)
                    data_next = right_data;
                else if (kp1 == ctl.fill)
                    data_next = '0;
            ACT_CLEAR:  data_next = '0;
            default:    ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            data_reg <= '0;
        else
            data_reg <= data_next;
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
        acc_reg <= acc_next;
    end

    assign data = data_reg;
    assign tag  = tag_reg;
    assign acc  = acc_reg;

endmodule

// File: rtl/core/byte_list_engine_core.sv
// byte list engine top level: request control and the row of list cells
//
//  channel | signals                     | direction | payload
//  --------+-----------------------------+-----------+-----------
//  request | req_valid, req_ready, req   | in        | ble_req_t
//  result  | rsp_valid, rsp_ready, rsp   | out       | ble_rsp_t
//
// push, insert, clear and length go from transfer straight to completion
// pop, remove, count, index, max, min and reverse first pass the sweep state:
// the reduction wave, and for reverse the odd-even swaps, run once on the row
// one request is in work at a time; a result waits in its output register
// while the next request is taken
// reset clears the list, the length and the control state

module byte_list_engine_core import ble_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  ble_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output ble_rsp_t rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_DONE
    } state_t;

    state_t            state_reg;
    ble_req_t          req_reg;
    ble_rsp_t          rsp_reg, rsp_next;
    logic              rsp_valid_reg;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [IDX_W-1:0]  sweep_cnt_reg;

    logic [7:0]       cell_data  [CAPACITY];
    logic [IDX_W-1:0] cell_tag   [CAPACITY];
    ble_acc_t         cell_acc   [CAPACITY];
    logic [7:0]       left_d     [CAPACITY];
    logic [7:0]       right_d    [CAPACITY];
    logic [IDX_W-1:0] left_t     [CAPACITY];
    logic [IDX_W-1:0] right_t    [CAPACITY];
    ble_acc_t         acc_chain  [CAPACITY];

    ble_ctl_t   ctl;
    ble_acc_t   acc0;
    logic [3:0] op_sel;
    logic       accept, needs_sweep, out_free, done_fire, list_full, list_empty;
    act_t       act;

    assign accept     = req_valid && req_ready;
    assign req_ready  = state_reg == S_IDLE;
    assign out_free   = !rsp_valid_reg || rsp_ready;
    assign done_fire  = (state_reg == S_DONE) && out_free;
    assign acc0       = cell_acc[0];
    assign list_full  = fill_reg == FILL_W'(CAPACITY);
    assign list_empty = fill_reg == '0;
    assign op_sel     = (state_reg == S_IDLE) ? req.req_type : req_reg.req_type;

    always_comb
    begin
        case (req.req_type) inside
            REQ_POP, REQ_REMOVE, REQ_COUNT, REQ_INDEX,
            REQ_MAX, REQ_MIN, REQ_REVERSE: needs_sweep = 1'b1;
            default:                        needs_sweep = 1'b0;
        endcase
    end

    // broadcast control for the cell row
    always_comb
    begin
        ctl.load    = accept;
        ctl.sweep   = state_reg == S_SWEEP;
        ctl.swap_en = req_reg.req_type == REQ_REVERSE;
        ctl.phase   = sweep_cnt_reg[0];
        case (op_sel)
            REQ_MAX: ctl.red_mode = RED_MAX;
            REQ_MIN: ctl.red_mode = RED_MIN;
            default: ctl.red_mode = RED_LAST;
        endcase
        ctl.action    = done_fire ? act : ACT_NONE;
        ctl.fill      = CMP_W'(fill_reg);
        ctl.pos       = CMP_W'(req_reg.position);
        ctl.value     = (state_reg == S_IDLE) ? req.value : req_reg.value;
        ctl.rm_idx    = acc0.idx;
        ctl.ident.hit = 1'b0;
        ctl.ident.val = (op_sel == REQ_MIN) ? 8'hFF : 8'h00;
        ctl.ident.cnt = '0;
        ctl.ident.idx = '0;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                assign left_d[gi] = '0;
                assign left_t[gi] = '0;
            end
            else
            begin : g_mid_l
                assign left_d[gi] = cell_data[gi-1];
                assign left_t[gi] = cell_tag[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_d[gi]   = '0;
                assign right_t[gi]   = '0;
                assign acc_chain[gi] = ctl.ident;
            end
            else
            begin : g_mid_r
                assign right_d[gi]   = cell_data[gi+1];
                assign right_t[gi]   = cell_tag[gi+1];
                assign acc_chain[gi] = cell_acc[gi+1];
            end

            ble_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .cell_index (IDX_W'(gi)),
                .ctl        (ctl),
                .left_data  (left_d[gi]),
                .left_tag   (left_t[gi]),
                .right_data (right_d[gi]),
                .right_tag  (right_t[gi]),
                .acc_in     (acc_chain[gi]),
                .data       (cell_data[gi]),
                .tag        (cell_tag[gi]),
                .acc        (cell_acc[gi])
            );
        end
    endgenerate

    // outcome of the request held in req_reg
    always_comb
    begin
        rsp_next  = '0;
        fill_next = fill_reg;
        act       = ACT_NONE;
        rsp_next.status = ST_OK;
        case (req_reg.req_type)
            REQ_PUSH:
                if (list_full)
                    rsp_next.status = ST_FULL;
                else
                begin
                    act       = ACT_PUSH;
                    fill_next = fill_reg + FILL_W'(1);
                end
            REQ_POP:
                if (list_empty)
                    rsp_next.status = ST_EMPTY;
                else
                begin
                    act                   = ACT_POP;
                    fill_next             = fill_reg - FILL_W'(1);
                    rsp_next.result_value = acc0.val;
                end
            REQ_INSERT:
                if (list_full)
                    rsp_next.status = ST_FULL;
                else if (CMP_W'(req_reg.position) > CMP_W'(fill_reg))
                    rsp_next.status = ST_BADPOS;
                else
                begin
                    act       = ACT_INSERT;
                    fill_next = fill_reg + FILL_W'(1);
                end
            REQ_REMOVE:
                if (list_empty)
                    rsp_next.status = ST_EMPTY;
                else if (!acc0.hit)
                    rsp_next.status = ST_NOTFOUND;
                else
                begin
                    act       = ACT_REMOVE;
                    fill_next = fill_reg - FILL_W'(1);
                end
            REQ_COUNT:
                rsp_next.match_count = 7'(acc0.cnt);
            REQ_INDEX:
                if (list_empty)
                    rsp_next.status = ST_EMPTY;
                else if (!acc0.hit)
                    rsp_next.status = ST_NOTFOUND;
                else
                    rsp_next.found_index = 6'(acc0.idx);
            REQ_MAX, REQ_MIN:
                if (list_empty)
                    rsp_next.status = ST_EMPTY;
                else
                    rsp_next.result_value = acc0.val;
            REQ_CLEAR:
            begin
                act       = ACT_CLEAR;
                fill_next = '0;
            end
            default: ;
        endcase
        rsp_next.list_length = 7'(fill_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_reg       <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            fill_reg      <= '0;
            sweep_cnt_reg <= '0;
        end
        else
        begin
            if (rsp_ready && !done_fire)
                rsp_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (req_valid)
                    begin
                        req_reg       <= req;
                        sweep_cnt_reg <= '0;
                        state_reg     <= needs_sweep ? S_SWEEP : S_DONE;
                    end
                S_SWEEP:
                begin
                    sweep_cnt_reg <= sweep_cnt_reg + IDX_W'(1);
                    if (sweep_cnt_reg == IDX_W'(CAPACITY - 1))
                        state_reg <= S_DONE;
                end
                S_DONE:
                    if (out_free)
                    begin
                        rsp_reg       <= rsp_next;
                        rsp_valid_reg <= 1'b1;
                        fill_reg      <= fill_next;
                        state_reg     <= S_IDLE;
                    end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(CAPACITY))
        else $error("list length above capacity");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside completion");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        done_fire && req_reg.req_type == REQ_PUSH && !list_full
        |=> fill_reg == $past(fill_reg) + FILL_W'(1))
        else $error("push did not grow the list");

    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.status == ST_EMPTY |-> rsp_reg.list_length == 7'd0)
        else $error("empty status with nonzero length");
`endif

endmodule
